// ===== rtl/fpmd_pkg.sv =====
package fpmd_pkg;

  // Fixed-point and saturation constants of the 16.16 format.
  localparam int unsigned FracBits  = 16;
  localparam int unsigned SatShift  = 14;
  localparam logic [31:0] FracRound = 32'h0000_FFFF;
  localparam logic [31:0] ValueMin  = 32'h8000_0000;
  localparam logic [31:0] ValueMax  = 32'h7FFF_FFFF;

  // Operation codes carried in the mode field.
  localparam logic OpMul = 1'b0;
  localparam logic OpDiv = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new word and take operand magnitudes
    logic mul;        // form the magnitude product
    logic check;      // evaluate the divide saturation test
    logic align;      // shift the divisor up by one place
    logic div_step;   // one restoring shift-subtract step
    logic out_load;   // write the output register
  } fpmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;       // operation of the word in flight
    logic sat_hit;    // dividend at least 2^14 times divisor, or divisor is zero
    logic align_more; // remainder still above the divisor
    logic div_last;   // this division step is the final one
  } fpmd_status_t;

endpackage

// ===== rtl/fpmd_if.sv =====
// Input channel: mode and two signed 16.16 operands.
interface fpmd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b,
                output ready);
endinterface

// Output channel: signed 16.16 result and saturation flag.
interface fpmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink (input valid, input value, input saturated, output ready);
endinterface

// ===== rtl/fixed_point_mul_div_16_16.sv =====
// Signed 16.16 fixed-point multiply/divide unit. One word is worked on at a time; a
// finished result sits in an output register, so the next word is taken while it waits.
// A multiply passes from acceptance through a decode state, one 32x32 magnitude
// product and a rounding/negate stage into the output register, which waits until
// the output register is free. A divide decodes, then makes k (0 to 14) divisor
// alignment shifts and n (1 to 17 + k) restoring shift-subtract steps, one quotient bit
// per cycle, ending early when the remainder reaches zero; a saturating divide goes from
// the overflow check straight to the output stage. The input is ready again in the cycle
// after the result is loaded, so the divide iteration is what bounds throughput.
module fixed_point_mul_div_16_16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpmd_in_if.sink    in_i,
  fpmd_out_if.source out_o
);
  import fpmd_pkg::*;

  fpmd_cmd_t    cmd;
  fpmd_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic [31:0]  value;
  logic         saturated;

  fpmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fpmd_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .mode_i      (in_i.mode),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .status_o    (status),
    .value_o     (value),
    .saturated_o (saturated)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.value     = value;
  assign out_o.saturated = saturated;

endmodule

// ===== rtl/fpmd_dp.sv =====
module fpmd_dp (
  input  logic                   clk_i,
  input  fpmd_pkg::fpmd_cmd_t    cmd_i,
  input  logic                   mode_i,
  input  logic [31:0]            operand_a_i,
  input  logic [31:0]            operand_b_i,
  output fpmd_pkg::fpmd_status_t status_o,
  output logic [31:0]            value_o,
  output logic                   saturated_o
);
  import fpmd_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [31:0] dv_q, dv_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  bit_q, bit_d;
  logic [63:0] prod_q, prod_d;
  logic        neg_q, neg_d;
  logic        mode_q, mode_d;
  logic        sat_q, sat_d;
  logic [31:0] value_q, value_d;
  logic        saturated_q, saturated_d;

  logic [31:0] mag_a, mag_b;
  logic        ge;
  logic [31:0] rem_sub, rem_after, rem_next;
  logic [47:0] mul_sum;
  logic [31:0] mul_mag, mul_res, div_res;

  // Operand magnitudes; the most negative value maps to 2^31.
  assign mag_a = operand_a_i[31] ? (32'd0 - operand_a_i) : operand_a_i;
  assign mag_b = operand_b_i[31] ? (32'd0 - operand_b_i) : operand_b_i;

  // One restoring step: subtract when it fits, then shift with wrap.
  assign ge        = (rem_q >= dv_q);
  assign rem_sub   = rem_q - dv_q;
  assign rem_after = ge ? rem_sub : rem_q;
  assign rem_next  = {rem_after[30:0], 1'b0};

  // Multiply finish: floor correction on negative answers, keep bits 47:16.
  assign mul_sum = prod_q[47:0] + (neg_q ? {16'd0, FracRound} : 48'd0);
  assign mul_mag = mul_sum[FracBits +: 32];
  assign mul_res = neg_q ? (32'd0 - mul_mag) : mul_mag;

  // Divide finish: saturate or apply the sign.
  always_comb begin
    if (sat_q) begin
      div_res = neg_q ? ValueMin : ValueMax;
    end else begin
      div_res = neg_q ? (32'd0 - quo_q) : quo_q;
    end
  end

  // Next-state selection for the working registers.
  always_comb begin
    rem_d       = rem_q;
    dv_d        = dv_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    mode_d      = mode_q;
    sat_d       = sat_q;
    value_d     = value_q;
    saturated_d = saturated_q;
    if (cmd_i.load) begin
      rem_d  = mag_a;
      dv_d   = mag_b;
      quo_d  = 32'd0;
      bit_d  = 5'(FracBits);
      neg_d  = operand_a_i[31] ^ operand_b_i[31];
      mode_d = mode_i;
      sat_d  = 1'b0;
    end
    if (cmd_i.mul) begin
      prod_d = {32'd0, rem_q} * {32'd0, dv_q};
    end
    if (cmd_i.check) begin
      sat_d = status_o.sat_hit;
    end
    if (cmd_i.align) begin
      dv_d  = {dv_q[30:0], 1'b0};
      bit_d = bit_q + 5'd1;
    end
    if (cmd_i.div_step) begin
      rem_d = rem_next;
      quo_d = quo_q | (ge ? (32'd1 << bit_q) : 32'd0);
      bit_d = bit_q - 5'd1;
    end
    if (cmd_i.out_load) begin
      value_d     = (mode_q == OpDiv) ? div_res : mul_res;
      saturated_d = (mode_q == OpDiv) && sat_q;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    dv_q        <= dv_d;
    quo_q       <= quo_d;
    bit_q       <= bit_d;
    prod_q      <= prod_d;
    neg_q       <= neg_d;
    mode_q      <= mode_d;
    sat_q       <= sat_d;
    value_q     <= value_d;
    saturated_q <= saturated_d;
  end

  // Status back to the controller.
  assign status_o.mode       = mode_q;
  assign status_o.sat_hit    = ((rem_q >> SatShift) >= dv_q);
  assign status_o.align_more = (rem_q > dv_q);
  assign status_o.div_last   = (bit_q == 5'd0) || (rem_next == 32'd0);

  assign value_o     = value_q;
  assign saturated_o = saturated_q;

endmodule

// ===== rtl/fpmd_ctrl.sv =====
module fpmd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  fpmd_pkg::fpmd_status_t status_i,
  output fpmd_pkg::fpmd_cmd_t    cmd_o
);
  import fpmd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StAlign = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer for one word at a time.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (status_i.mode == OpMul) begin
          state_d = StMul;
        end else begin
          cmd_o.check = 1'b1;
          state_d     = status_i.sat_hit ? StDone : StAlign;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDone;
      end
      StAlign: begin
        if (status_i.align_more) begin
          cmd_o.align = 1'b1;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
